/* src/ecv_pkg.sv */
// Shared types, constants and the sine table generator for the easing curve evaluator.
// Depends on nothing; used by ecv_divider and easing_curve_evaluator.
package ecv_pkg;

  // Default size of the sine table, log2 of its entry count (6 to 14)
  localparam int SINE_TABLE_BITS_DEF = 10;

  // Step counter width and quotient width of the step-mode divider
  localparam int STEP_W        = 12;
  localparam int QUO_W         = 32;
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_STAGES    = QUO_W / DIV_STEP_BITS;

  // Curve modes
  localparam logic [2:0] MODE_LINEAR = 3'd0;
  localparam logic [2:0] MODE_HOLD   = 3'd1;
  localparam logic [2:0] MODE_SINE   = 3'd2;
  localparam logic [2:0] MODE_BOUNCE = 3'd3;
  localparam logic [2:0] MODE_STEPS  = 3'd4;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_CURVE_MODE     = 3'd0;
  localparam logic [2:0] REG_START_VALUE    = 3'd1;
  localparam logic [2:0] REG_END_VALUE      = 3'd2;
  localparam logic [2:0] REG_SINE_CYCLES    = 3'd3;
  localparam logic [2:0] REG_SINE_AMPLITUDE = 3'd4;
  localparam logic [2:0] REG_STEP_COUNT     = 3'd5;

  // Quarter-wave odd polynomial, Q30 coefficients
  localparam longint PA1 = 64'sd1686629713;
  localparam longint PA3 = -64'sd693598563;
  localparam longint PA5 = 64'sd85569278;
  localparam longint PA7 = -64'sd4858604;

  // Partial remainder and shifting dividend/quotient of the restoring divider
  typedef struct packed {
    logic [STEP_W-1:0] rem;
    logic [QUO_W-1:0]  nq;
  } div_word_t;

  // Sine table entry, Q16 in [-65536, 65536]; evaluated at elaboration only
  function automatic logic signed [17:0] sine_entry(input int idx, input int table_bits);
    int     qbits;
    int     quad;
    longint x;
    longint xx;
    longint x2;
    longint t;
    longint s;
    qbits = table_bits - 2;
    quad  = (idx >>> qbits) & 3;
    x     = longint'(idx & ((1 << qbits) - 1)) << (16 - qbits);
    if ((quad & 1) != 0) x = 64'sd65536 - x;
    xx = x << 14;
    x2 = (xx * xx) >>> 30;
    t  = PA7;
    t  = PA5 + ((t * x2) >>> 30);
    t  = PA3 + ((t * x2) >>> 30);
    t  = PA1 + ((t * x2) >>> 30);
    s  = (t * xx) >>> 30;
    s  = (s + 64'sd8192) >>> 14;
    if (s > 64'sd65536) s = 64'sd65536;
    if (s < 64'sd0) s = 64'sd0;
    if ((quad & 2) != 0) s = -s;
    return 18'(s);
  endfunction

endpackage

/* src/ecv_divider.sv */
// Pipelined restoring divider for steps mode: DIV_STAGES stages, DIV_STEP_BITS bits each.
// Depends on ecv_pkg (div_word_t, widths). Valid bits are kept by the caller.
module ecv_divider (
  input  logic                                clk,
  input  logic [ecv_pkg::DIV_STAGES-1:0]      en,
  input  logic [ecv_pkg::STEP_W-1:0]          divisor,
  input  ecv_pkg::div_word_t                  word_in,
  output ecv_pkg::div_word_t                  word_out
);

  // A few restoring steps: shift one dividend bit into the remainder, subtract if it fits
  function automatic ecv_pkg::div_word_t div_steps(input ecv_pkg::div_word_t w,
                                                   input logic [ecv_pkg::STEP_W-1:0] dvs);
    logic [ecv_pkg::STEP_W:0] t;
    ecv_pkg::div_word_t       r;
    r = w;
    for (int i = 0; i < ecv_pkg::DIV_STEP_BITS; i++) begin
      t    = {r.rem, r.nq[ecv_pkg::QUO_W-1]};
      r.nq = {r.nq[ecv_pkg::QUO_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        r.rem   = ecv_pkg::STEP_W'(t - {1'b0, dvs});
        r.nq[0] = 1'b1;
      end else begin
        r.rem = t[ecv_pkg::STEP_W-1:0];
      end
    end
    return r;
  endfunction

  ecv_pkg::div_word_t stage_q [ecv_pkg::DIV_STAGES];

  for (genvar g = 0; g < ecv_pkg::DIV_STAGES; g++) begin : g_stage
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[g]) stage_q[g] <= div_steps(word_in, divisor);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en[g]) stage_q[g] <= div_steps(stage_q[g-1], divisor);
      end
    end
  end

  assign word_out = stage_q[ecv_pkg::DIV_STAGES-1];

endmodule

/* src/easing_curve_evaluator.sv */
// Easing curve evaluator top level: config registers, 15-stage datapath, sine ROM.
// Depends on ecv_pkg and ecv_divider.
//
// Each weight word (Q0.16, 65536 = 1.0, larger values act as 1.0) yields one eased
// value (signed Q16.16, rounded, saturated) between start_value and end_value, in the
// curve mode set by curve_mode. One word enters per clock while weight_stall is low; the
// pipeline depth is set by the steps-mode divider (eight stages of four quotient bits)
// plus the sine ROM read, the multiplier stages and the final rounding.
// Bubbles are squeezed out, so a stalled output still lets words enter until the
// pipeline is full. The sine table holds 2^SINE_TABLE_BITS entries built at
// elaboration and read through a registered port. Configuration writes are always
// taken (cfg_ready is tied high) and must only be made while no word is in flight.
module easing_curve_evaluator #(
  parameter int SINE_TABLE_BITS = ecv_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  // weight channel
  input  logic                weight_valid,
  output logic                weight_stall,
  input  logic [16:0]         weight,
  // result channel
  output logic                eased_valid,
  input  logic                eased_stall,
  output logic signed [31:0]  eased_value
);

  localparam int SINE_DEPTH = 1 << SINE_TABLE_BITS;
  localparam int ACC_W      = 52;

  // stage numbers
  localparam int ST_IN    = 0;
  localparam int ST_IDX   = 1;
  localparam int ST_PROD  = 2;
  localparam int ST_MIX   = 3;
  localparam int ST_ACC   = 4;
  localparam int DIV_LAST = ST_ACC + ecv_pkg::DIV_STAGES - 1;
  localparam int ST_BASE  = 5;
  localparam int ST_FIX   = DIV_LAST + 1;
  localparam int ST_SUM   = ST_FIX + 1;
  localparam int ST_OUT   = ST_SUM + 1;
  localparam int NUM_ST   = ST_OUT + 1;

  // bounce segment limits and offsets, x11 = 11 * weight
  localparam logic [19:0]        BNC_LIM1 = 20'd262144;
  localparam logic [19:0]        BNC_LIM2 = 20'd524288;
  localparam logic [19:0]        BNC_LIM3 = 20'd655360;
  localparam logic signed [20:0] BNC_OFS1 = 21'sd393216;
  localparam logic signed [20:0] BNC_OFS2 = 21'sd589824;
  localparam logic [20:0]        BNC_OFS3 = 21'd1376256;

  localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
  localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

  typedef enum logic [1:0] {
    BNC_SEG_RISE,
    BNC_SEG_FIRST,
    BNC_SEG_SECOND,
    BNC_SEG_LAST
  } bnc_seg_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [2:0]                  curve_mode;
  logic signed [31:0]          start_value;
  logic signed [31:0]          end_value;
  logic [23:0]                 sine_cycles;
  logic signed [31:0]          sine_amplitude;
  logic [ecv_pkg::STEP_W-1:0]  step_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode     <= ecv_pkg::MODE_LINEAR;
      start_value    <= 32'sd0;
      end_value      <= 32'sd65536;
      sine_cycles    <= 24'd65536;
      sine_amplitude <= 32'sd16384;
      step_count     <= 12'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ecv_pkg::REG_CURVE_MODE:     curve_mode     <= cfg_data[2:0];
        ecv_pkg::REG_START_VALUE:    start_value    <= cfg_data;
        ecv_pkg::REG_END_VALUE:      end_value      <= cfg_data;
        ecv_pkg::REG_SINE_CYCLES:    sine_cycles    <= cfg_data[23:0];
        ecv_pkg::REG_SINE_AMPLITUDE: sine_amplitude <= cfg_data;
        ecv_pkg::REG_STEP_COUNT:     step_count     <= cfg_data[ecv_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived config, registered from the configuration registers
  logic signed [32:0] diff_q;
  logic               flat_q;

  always_ff @(posedge clk) begin
    diff_q <= 33'(end_value) - 33'(start_value);
    flat_q <= (step_count == '0) || (end_value == start_value);
  end

  // Mode decode; unused codes act as linear
  logic is_hold, is_sine, is_bounce, is_steps;

  always_comb begin
    is_hold   = 1'b0;
    is_sine   = 1'b0;
    is_bounce = 1'b0;
    is_steps  = 1'b0;
    unique case (curve_mode)
      ecv_pkg::MODE_HOLD:   is_hold   = 1'b1;
      ecv_pkg::MODE_SINE:   is_sine   = 1'b1;
      ecv_pkg::MODE_BOUNCE: is_bounce = 1'b1;
      ecv_pkg::MODE_STEPS:  is_steps  = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage moves when empty or when the next one moves
  logic [NUM_ST-1:0] vld;
  logic [NUM_ST:0]   adv;

  assign adv[NUM_ST] = !eased_stall;
  for (genvar k = 0; k < NUM_ST; k++) begin : g_adv
    assign adv[k] = !vld[k] || adv[k+1];
  end

  assign weight_stall = !adv[ST_IN];
  assign eased_valid  = vld[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[ST_IN]) vld[ST_IN] <= weight_valid;
      for (int k = 1; k < NUM_ST; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sine table, constant entries, registered read
  logic signed [17:0] sine_rom [SINE_DEPTH];

  for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_sine_rom
    localparam logic signed [17:0] ENTRY = ecv_pkg::sine_entry(g, SINE_TABLE_BITS);
    assign sine_rom[g] = ENTRY;
  end

  // ---------------------------------------------------------------------------
  // Side lines: weight-at-one flag, divider sign, accumulated value
  logic                    full_line [ST_IN:ST_SUM];
  logic                    neg_line  [ST_MIX:DIV_LAST];
  logic signed [ACC_W-1:0] acc_line  [ST_BASE:ST_FIX];

  for (genvar k = ST_IN + 1; k <= ST_SUM; k++) begin : g_full_line
    always_ff @(posedge clk) begin
      if (adv[k]) full_line[k] <= full_line[k-1];
    end
  end

  for (genvar k = ST_MIX + 1; k <= DIV_LAST; k++) begin : g_neg_line
    always_ff @(posedge clk) begin
      if (adv[k]) neg_line[k] <= neg_line[k-1];
    end
  end

  for (genvar k = ST_BASE + 1; k <= ST_FIX; k++) begin : g_acc_line
    always_ff @(posedge clk) begin
      if (adv[k]) acc_line[k] <= acc_line[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage: clamp weight to 1.0
  logic [16:0] w0;

  always_ff @(posedge clk) begin
    if (adv[ST_IN]) begin
      w0              <= weight[16] ? 17'h10000 : weight;
      full_line[ST_IN] <= weight[16];
    end
  end

  // ---------------------------------------------------------------------------
  // Index stage: sine phase, bounce segment, step number
  logic [40:0]                 phase_c;
  logic [19:0]                 x11_c;
  logic [28:0]                 cur_c;
  logic signed [20:0]          u_c;
  bnc_seg_t                    seg_c;

  logic [16:0]                 w1;
  logic [SINE_TABLE_BITS-1:0]  idx1;
  logic signed [20:0]          u1;
  bnc_seg_t                    seg1;
  logic [ecv_pkg::STEP_W-1:0]  cur1;

  assign phase_c = w0 * sine_cycles;
  assign x11_c   = w0 * 20'd11;
  assign cur_c   = w0 * step_count;

  always_comb begin
    priority if (x11_c < BNC_LIM1) begin
      seg_c = BNC_SEG_RISE;
      u_c   = $signed({1'b0, x11_c});
    end else if (x11_c < BNC_LIM2) begin
      seg_c = BNC_SEG_FIRST;
      u_c   = $signed({1'b0, x11_c}) - BNC_OFS1;
    end else if (x11_c < BNC_LIM3) begin
      seg_c = BNC_SEG_SECOND;
      u_c   = $signed({1'b0, x11_c}) - BNC_OFS2;
    end else begin
      // last segment uses 22*x, wraps correctly in 21 bits
      seg_c = BNC_SEG_LAST;
      u_c   = $signed({x11_c, 1'b0} - BNC_OFS3);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_IDX]) begin
      w1   <= w0;
      idx1 <= phase_c[31 -: SINE_TABLE_BITS];
      u1   <= u_c;
      seg1 <= seg_c;
      cur1 <= cur_c[27:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Product stage: table read, u squared, d*cur, d*w
  logic signed [41:0] usq_c;
  logic signed [45:0] dc_c;
  logic signed [50:0] dw_c;

  logic signed [17:0] sn2;
  logic [36:0]        usq2;
  bnc_seg_t           seg2;
  logic signed [45:0] dc2;
  logic signed [50:0] dw2;

  assign usq_c = u1 * u1;
  assign dc_c  = diff_q * $signed({1'b0, cur1});
  assign dw_c  = diff_q * $signed({1'b0, w1});

  always_ff @(posedge clk) begin
    if (adv[ST_PROD]) begin
      sn2  <= sine_rom[idx1];
      usq2 <= usq_c[36:0];
      seg2 <= seg1;
      dc2  <= dc_c;
      dw2  <= dw_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Mix stage: sine term, bounce curve value, divider operand
  logic signed [49:0]  as_c;
  logic [37:0]         p36_c;
  logic [37:0]         prnd_c;
  logic signed [45:0]  mag_c;
  ecv_pkg::div_word_t  div_c;

  logic signed [49:0]  as3;
  logic [16:0]         p3;
  logic signed [50:0]  dw3;
  ecv_pkg::div_word_t  div3;

  assign as_c = sine_amplitude * sn2;

  always_comb begin
    unique case (seg2)
      BNC_SEG_RISE:   p36_c = {1'b0, usq2};
      BNC_SEG_FIRST:  p36_c = {1'b0, usq2} + (38'd3 << 34);
      BNC_SEG_SECOND: p36_c = {1'b0, usq2} + (38'd15 << 32);
      BNC_SEG_LAST:   p36_c = {3'b0, usq2[36:2]} + (38'd63 << 30);
    endcase
  end

  assign prnd_c = p36_c + 38'd524288;

  // unsigned divide on the magnitude; top part is below the divisor
  assign mag_c     = dc2[45] ? -dc2 : dc2;
  assign div_c.rem = mag_c[43:32];
  assign div_c.nq  = mag_c[31:0];

  always_ff @(posedge clk) begin
    if (adv[ST_MIX]) begin
      as3              <= as_c;
      p3               <= prnd_c[36:20];
      dw3              <= dw2;
      div3             <= div_c;
      neg_line[ST_MIX] <= dc2[45];
    end
  end

  // ---------------------------------------------------------------------------
  // Accumulate stage: mode product or sum, then add start value
  logic signed [50:0]      dp_c;
  logic signed [ACC_W-1:0] acc_c;
  logic signed [ACC_W-1:0] acc4;
  logic signed [ACC_W-1:0] base_c;

  assign dp_c = diff_q * $signed({1'b0, p3});

  always_comb begin
    priority if (is_bounce) begin
      acc_c = ACC_W'(dp_c);
    end else if (is_sine) begin
      acc_c = ACC_W'(dw3) + ACC_W'(as3);
    end else begin
      acc_c = ACC_W'(dw3);
    end
  end

  assign base_c = ACC_W'(start_value) <<< 16;

  always_ff @(posedge clk) begin
    if (adv[ST_ACC]) acc4 <= acc_c;
  end

  always_ff @(posedge clk) begin
    if (adv[ST_BASE]) acc_line[ST_BASE] <= base_c + acc4;
  end

  // ---------------------------------------------------------------------------
  // Steps-mode divider
  ecv_pkg::div_word_t div_out;

  ecv_divider u_divider (
    .clk      (clk),
    .en       (adv[DIV_LAST:ST_ACC]),
    .divisor  (step_count),
    .word_in  (div3),
    .word_out (div_out)
  );

  // ---------------------------------------------------------------------------
  // Fix stage: floor quotient and remainder of the signed product
  logic signed [33:0]         qf_c;
  logic [ecv_pkg::STEP_W-1:0] rf_c;
  logic signed [33:0]         qf12;
  logic [ecv_pkg::STEP_W-1:0] rf12;

  always_comb begin
    priority if (!neg_line[DIV_LAST]) begin
      qf_c = $signed({2'b00, div_out.nq});
      rf_c = div_out.rem;
    end else if (div_out.rem == '0) begin
      qf_c = -$signed({2'b00, div_out.nq});
      rf_c = '0;
    end else begin
      qf_c = $signed(~{2'b00, div_out.nq});
      rf_c = step_count - div_out.rem;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_FIX]) begin
      qf12 <= qf_c;
      rf12 <= rf_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Sum stage: rounded step value, rounded accumulator
  logic                    rbit_c;
  logic signed [33:0]      stp_c;
  logic signed [ACC_W-1:0] rnd_c;
  logic signed [33:0]      stp13;
  logic signed [35:0]      accr13;

  assign rbit_c = ({rf12, 1'b0} >= {1'b0, step_count});
  assign stp_c  = 34'(start_value) + qf12 + {33'b0, rbit_c};
  assign rnd_c  = acc_line[ST_FIX] + 52'sd32768;

  always_ff @(posedge clk) begin
    if (adv[ST_SUM]) begin
      stp13  <= stp_c;
      accr13 <= rnd_c[ACC_W-1:16];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: mode select and saturation
  logic signed [35:0] sel_c;
  logic signed [31:0] sat_c;
  logic signed [31:0] res_c;
  logic signed [31:0] out_q;

  assign sel_c = is_steps ? 36'(stp13) : accr13;

  always_comb begin
    priority if (sel_c > SAT_MAX) begin
      sat_c = SAT_MAX[31:0];
    end else if (sel_c < SAT_MIN) begin
      sat_c = SAT_MIN[31:0];
    end else begin
      sat_c = sel_c[31:0];
    end
  end

  always_comb begin
    priority if (is_hold) begin
      res_c = full_line[ST_SUM] ? end_value : start_value;
    end else if (is_steps && flat_q) begin
      res_c = start_value;
    end else begin
      res_c = sat_c;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_OUT]) out_q <= res_c;
  end

  assign eased_value = out_q;

endmodule

/* tb/ecv_result_checker.sv */
// Result checker for the easing curve evaluator: mirrors the config registers,
// predicts each eased value from the accepted weight and compares it in order.
// Depends on ecv_pkg for the curve mode and register index codes.
module ecv_result_checker #(
  parameter int SINE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               weight_valid,
  input  logic               weight_stall,
  input  logic [16:0]        weight,
  input  logic               eased_valid,
  input  logic               eased_stall,
  input  logic signed [31:0] eased_value,
  output int                 mismatch_count,
  output int                 pending_results,
  output int                 checked_results
);

  // Quarter-wave sine polynomial, Q30
  localparam longint COEF_1 = 64'sd1686629713;
  localparam longint COEF_3 = -64'sd693598563;
  localparam longint COEF_5 = 64'sd85569278;
  localparam longint COEF_7 = -64'sd4858604;
  localparam longint ONE_Q16 = 64'sd65536;

  typedef struct packed {
    logic [16:0]        w;
    logic signed [31:0] value;
  } eased_expect_t;

  eased_expect_t expected_eased[$];

  // Local copy of the configuration registers
  logic [2:0]         cur_mode;
  logic signed [31:0] cur_start;
  logic signed [31:0] cur_end;
  logic [23:0]        cur_cycles;
  logic signed [31:0] cur_amp;
  logic [11:0]        cur_steps;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return 32'(v);
  endfunction

  // drop 16 extra fraction bits, round half up, saturate
  function automatic logic signed [31:0] round_q16(input longint acc);
    return clamp32((acc + 64'sd32768) >>> 16);
  endfunction

  // floor division, den > 0
  function automatic longint floor_div(input longint num, input longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  // sin(pi/2 * x), x in Q0.16, result Q30
  function automatic longint quarter_wave(input longint x);
    longint xx;
    longint x2;
    longint t;
    xx = x <<< 14;
    x2 = (xx * xx) >>> 30;
    t  = COEF_7;
    t  = COEF_5 + ((t * x2) >>> 30);
    t  = COEF_3 + ((t * x2) >>> 30);
    t  = COEF_1 + ((t * x2) >>> 30);
    return (t * xx) >>> 30;
  endfunction

  // full-wave table value for one index, Q16 clamped to +-1.0
  function automatic longint sine_q16(input int unsigned idx);
    int unsigned qbits;
    int unsigned quad;
    longint x;
    longint s;
    qbits = SINE_BITS - 2;
    quad  = (idx >> qbits) & 3;
    x     = longint'(idx & ((1 << qbits) - 1)) <<< (16 - qbits);
    if (quad[0]) x = ONE_Q16 - x;
    s = (quarter_wave(x) + 64'sd8192) >>> 14;
    if (s > ONE_Q16) s = ONE_Q16;
    if (s < 0) s = 0;
    return quad[1] ? -s : s;
  endfunction

  // ease-out-bounce, Q0.16 in and out, exact in Q36 before rounding
  function automatic longint bounce_q16(input longint x);
    longint x11;
    longint u;
    longint p;
    x11 = 11 * x;
    if (x11 < 4 * ONE_Q16) begin
      p = x11 * x11;
    end else if (x11 < 8 * ONE_Q16) begin
      u = x11 - 6 * ONE_Q16;
      p = u * u + (longint'(3) <<< 34);
    end else if (x11 < 10 * ONE_Q16) begin
      u = x11 - 9 * ONE_Q16;
      p = u * u + (longint'(15) <<< 32);
    end else begin
      u = 22 * x - 21 * ONE_Q16;
      p = (u * u) / 4 + (longint'(63) <<< 30);
    end
    return (p + (longint'(1) <<< 19)) >>> 20;
  endfunction

  function automatic logic signed [31:0] predict_eased(input logic [16:0] w_in);
    longint      w;
    longint      s;
    longint      e;
    longint      d;
    longint      base;
    longint      n;
    longint      cur;
    logic [63:0] phase;
    int unsigned idx;
    w = longint'(w_in);
    if (w > ONE_Q16) w = ONE_Q16;
    s    = longint'(cur_start);
    e    = longint'(cur_end);
    d    = e - s;
    base = s * ONE_Q16;
    case (cur_mode)
      ecv_pkg::MODE_HOLD: begin
        return clamp32((w < ONE_Q16) ? s : e);
      end
      ecv_pkg::MODE_SINE: begin
        // only the fraction of the phase picks the table entry
        phase = w * longint'(cur_cycles);
        idx   = phase[31:32-SINE_BITS];
        return round_q16(base + d * w + longint'(cur_amp) * sine_q16(idx));
      end
      ecv_pkg::MODE_BOUNCE: begin
        return round_q16(base + d * bounce_q16(w));
      end
      ecv_pkg::MODE_STEPS: begin
        n = longint'(cur_steps);
        if (n == 0 || d == 0) return clamp32(s);
        cur = (w * n) >>> 16;
        return clamp32(s + floor_div(2 * d * cur + n, 2 * n));
      end
      default: begin
        return round_q16(base + d * w);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [16:0] w,
                                 input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    mismatch_count++;
    $display("ERROR at %0t: %s, mode %0d weight %0d: got %0d, expected %0d",
             $time, what, cur_mode, w, got, want);
  endtask

  // Track config writes, predict on accepted weights, compare accepted results
  always @(posedge clk) begin : track
    eased_expect_t head;
    if (rst) begin
      cur_mode        = ecv_pkg::MODE_LINEAR;
      cur_start       = 32'sd0;
      cur_end         = 32'sd65536;
      cur_cycles      = 24'd65536;
      cur_amp         = 32'sd16384;
      cur_steps       = 12'd4;
      mismatch_count  = 0;
      checked_results = 0;
      expected_eased.delete();
    end else begin
      // config word
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ecv_pkg::REG_CURVE_MODE:     cur_mode   = cfg_data[2:0];
          ecv_pkg::REG_START_VALUE:    cur_start  = cfg_data;
          ecv_pkg::REG_END_VALUE:      cur_end    = cfg_data;
          ecv_pkg::REG_SINE_CYCLES:    cur_cycles = cfg_data[23:0];
          ecv_pkg::REG_SINE_AMPLITUDE: cur_amp    = cfg_data;
          ecv_pkg::REG_STEP_COUNT:     cur_steps  = cfg_data[11:0];
          default: ;
        endcase
      end
      // result word; a weight taken at this same edge cannot be its source
      if (eased_valid && !eased_stall) begin
        if (expected_eased.size() == 0) begin
          report_mismatch("eased value with none expected", '0, eased_value, '0);
        end else begin
          head = expected_eased.pop_front();
          checked_results++;
          if (eased_value !== head.value)
            report_mismatch("eased_value differs", head.w, eased_value, head.value);
        end
      end
      // weight word
      if (weight_valid && !weight_stall)
        expected_eased.push_back('{w: weight, value: predict_eased(weight)});
    end
    pending_results = expected_eased.size();
  end

endmodule

/* tb/tb.sv */
// Testbench top for the easing curve evaluator: clock, reset, weight and config
// stimulus, result back-pressure and the verdict. Depends on ecv_pkg,
// easing_curve_evaluator and ecv_result_checker.
module tb;

  localparam int TABLE_BITS        = ecv_pkg::SINE_TABLE_BITS_DEF;
  localparam int CYCLE_LIMIT       = 300000;
  localparam int HOLD_OFF_CYCLES   = 80;
  localparam int DRAIN_CYCLES      = 40;
  localparam int RANDOM_PHASES     = 12;
  localparam int WEIGHTS_PER_PHASE = 100;

  localparam logic [2:0]  MODE_SPARE   = 3'd7;
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;
  localparam logic [16:0] W_ONE        = 17'd65536;
  localparam logic [31:0] Q_MAX        = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN        = 32'h8000_0000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               weight_valid = 1'b0;
  logic               weight_stall;
  logic [16:0]        weight = '0;
  logic               eased_valid;
  logic               eased_stall = 1'b0;
  logic signed [31:0] eased_value;

  int mismatch_count;
  int pending_results;
  int checked_results;
  int weights_sent = 0;
  int settings_applied = 0;
  int cycle_count = 0;
  int src_pct = 0;
  int sink_pct = 0;
  int sink_burst = 0;
  bit holding = 1'b0;
  event hold_go;

  easing_curve_evaluator #(.SINE_TABLE_BITS(TABLE_BITS)) dut (.*);

  ecv_result_checker #(.SINE_BITS(TABLE_BITS)) result_check (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results);
      $display("Mismatches found");
      $finish;
    end
  end

  // Long receiver hold-off, counted on rising edges
  initial begin : hold_off
    forever begin
      @(hold_go);
      @(posedge clk);
      holding = 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      holding = 1'b0;
    end
  end

  // Result side stall: random bursts of random length
  always @(negedge clk) begin : result_sink
    if (holding) begin
      eased_stall <= 1'b1;
    end else if (sink_burst > 0) begin
      eased_stall <= 1'b1;
      sink_burst--;
    end else if (sink_pct != 0 && $urandom_range(99, 0) < sink_pct) begin
      eased_stall <= 1'b1;
      sink_burst = $urandom_range(9, 0);
    end else begin
      eased_stall <= 1'b0;
    end
  end

  // Offer one weight word and hold it until taken; returns on a falling edge
  task automatic send_weight(input logic [16:0] w);
    weight_valid <= 1'b1;
    weight       <= w;
    @(posedge clk);
    while (weight_stall) @(posedge clk);
    weights_sent++;
    @(negedge clk);
  endtask

  task automatic idle_source(input int n);
    weight_valid <= 1'b0;
    weight       <= 17'($urandom);
    repeat (n) @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic drain_weights();
    weight_valid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
  endtask

  // One config word; leaves cfg_valid high for a following write
  task automatic put_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write every register while idle; unused upper data bits are random
  task automatic apply_setting(input logic [2:0] mode_sel, input logic [31:0] from_q,
                               input logic [31:0] to_q, input logic [23:0] cyc_q,
                               input logic [31:0] amp_q, input logic [11:0] steps_n,
                               input bit with_spare);
    drain_weights();
    put_reg(ecv_pkg::REG_CURVE_MODE, (32'($urandom) & ~32'h7) | 32'(mode_sel));
    put_reg(ecv_pkg::REG_START_VALUE, from_q);
    put_reg(ecv_pkg::REG_END_VALUE, to_q);
    put_reg(ecv_pkg::REG_SINE_CYCLES, (32'($urandom) & 32'hff00_0000) | 32'(cyc_q));
    put_reg(ecv_pkg::REG_SINE_AMPLITUDE, amp_q);
    put_reg(ecv_pkg::REG_STEP_COUNT, (32'($urandom) & 32'hffff_f000) | 32'(steps_n));
    // writes to unmapped indexes must not disturb anything
    if (with_spare) begin
      put_reg(REG_SPARE_LO, $urandom);
      put_reg(REG_SPARE_HI, $urandom);
    end
    cfg_valid <= 1'b0;
    settings_applied++;
  endtask

  function automatic logic [16:0] pick_weight();
    case ($urandom_range(9, 0))
      0:       return 17'($urandom);
      1:       return W_ONE;
      2:       return 17'($urandom_range(15, 0));
      3:       return W_ONE - 17'($urandom_range(15, 0));
      default: return 17'($urandom_range(65536, 0));
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5, 0))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(32'h0028_0000, 0)) - 32'h0014_0000;
    endcase
  endfunction

  function automatic logic [23:0] pick_cycles();
    case ($urandom_range(4, 0))
      0:       return 24'd0;
      1:       return 24'hff_ffff;
      2:       return 24'($urandom);
      default: return 24'($urandom_range(32'h0008_0000, 0));
    endcase
  endfunction

  function automatic logic [11:0] pick_steps();
    case ($urandom_range(5, 0))
      0:       return 12'd0;
      1:       return 12'd4095;
      2:       return 12'd1;
      3:       return 12'($urandom);
      default: return 12'($urandom_range(16, 1));
    endcase
  endfunction

  function automatic logic [2:0] pick_mode();
    int m;
    m = $urandom_range(11, 0);
    if (m < 10) return 3'(m % 5);
    return 3'(ecv_pkg::MODE_STEPS + 1 + m % 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(3, 0))
      0:       return 0;
      1:       return 5;
      2:       return 20;
      default: return 50;
    endcase
  endfunction

  task automatic run_weights(input int count, input bit pause_midway);
    for (int k = 0; k < count; k++) begin
      // sender waits for a full drain once, halfway through
      if (pause_midway && k == count / 2) drain_weights();
      if (src_pct != 0 && $urandom_range(99, 0) < src_pct)
        idle_source($urandom_range(10, 1));
      send_weight(pick_weight());
    end
  endtask

  initial begin : stimulus
    logic [2:0] mode_pick;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset values: linear ramp 0 to 1.0, weights at and past one
    send_weight(17'd0);
    send_weight(17'd1);
    send_weight(17'd32768);
    send_weight(17'd65535);
    send_weight(W_ONE);
    send_weight(W_ONE + 17'd1);
    send_weight(17'h1_ffff);

    // Reset values of the sine and step registers, mode switched only
    drain_weights();
    put_reg(ecv_pkg::REG_CURVE_MODE, 32'(ecv_pkg::MODE_SINE));
    cfg_valid <= 1'b0;
    send_weight(17'd16384);
    send_weight(17'd49152);
    drain_weights();
    put_reg(ecv_pkg::REG_CURVE_MODE, 32'(ecv_pkg::MODE_STEPS));
    cfg_valid <= 1'b0;
    send_weight(17'd40000);

    // Bounce across its segment limits
    apply_setting(ecv_pkg::MODE_BOUNCE, 32'hfffd_0000, 32'h0005_0000, 24'd65536, 32'd0,
                  12'd4, 0);
    send_weight(17'd23831);
    send_weight(17'd47662);
    send_weight(17'd59578);
    send_weight(W_ONE);

    // Hold over the full signed range
    apply_setting(ecv_pkg::MODE_HOLD, Q_MIN, Q_MAX, 24'd65536, 32'd0, 12'd4, 0);
    send_weight(17'd65535);
    send_weight(W_ONE);

    // Sine pushing past the top: saturation
    apply_setting(ecv_pkg::MODE_SINE, Q_MAX, Q_MAX, 24'hff_ffff, Q_MAX, 12'd4, 0);
    send_weight(17'd16);
    send_weight(W_ONE);

    // Steps: zero count, then a flat span, then the largest count
    apply_setting(ecv_pkg::MODE_STEPS, 32'h0064_0000, 32'h00c8_0000, 24'd0, 32'd0,
                  12'd0, 0);
    send_weight(17'd40000);
    apply_setting(ecv_pkg::MODE_STEPS, 32'hfff9_0000, 32'hfff9_0000, 24'd0, 32'd0,
                  12'd7, 0);
    send_weight(17'd40000);
    apply_setting(ecv_pkg::MODE_STEPS, Q_MIN, Q_MAX, 24'd0, 32'd0, 12'd4095, 0);
    send_weight(17'd65535);
    send_weight(W_ONE);

    // Zero sine cycles and a spare mode code, with unmapped writes
    apply_setting(ecv_pkg::MODE_SINE, 32'h0001_0000, 32'hffff_0000, 24'd0, Q_MAX,
                  12'd4, 1);
    send_weight(17'd12345);
    apply_setting(MODE_SPARE, 32'h0010_0000, 32'hfff0_0000, 24'd3, 32'd9, 12'd3, 1);
    send_weight(17'd30000);

    // Random settings and weights
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      mode_pick = (ph < 8) ? 3'(ph) : pick_mode();
      if (ph == 0)
        apply_setting(mode_pick, Q_MIN, Q_MAX, 24'hff_ffff, Q_MAX, 12'd4095, 0);
      else if (ph == 1)
        apply_setting(mode_pick, Q_MAX, Q_MIN, 24'd1, Q_MIN, 12'd1, 0);
      else
        apply_setting(mode_pick, pick_value(), pick_value(), pick_cycles(),
                      pick_value(), pick_steps(), ph[0]);
      // the last phases run with no idling at all
      if (ph >= RANDOM_PHASES - 2) begin
        src_pct  = 0;
        sink_pct = 0;
      end else begin
        src_pct  = pick_pct();
        sink_pct = pick_pct();
      end
      // receiver holds off while the sender keeps offering: pipeline fills up
      if (ph == 2) begin
        src_pct = 0;
        -> hold_go;
      end
      run_weights(WEIGHTS_PER_PHASE, ph == 4);
    end

    drain_weights();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Ran %0d weights through %0d curve settings, %0d eased values compared.",
             weights_sent, settings_applied, checked_results);
    $display("Covered all curve modes, spare mode codes, saturation and back-pressure.");
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
